[sv/sorted_priority_queue_top_macros.svh]
// assertion macros shared by the queue's checker
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/spq_pkg.sv]
// shared constants, codes and types of the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PRIO_W    = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OCC_W     = 5;

  // action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [PRIO_BITS-1:0] prio_t;
  typedef logic [DATA_W-1:0]    data_t;

  // what a cell shows to its neighbors
  typedef struct packed {
    logic  keep;
    data_t data;
    prio_t prio;
  } cell_link_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic  en;
    logic  pop;
    data_t data;
    prio_t prio;
  } cell_cmd_t;

endpackage

[sv/sorted_priority_queue_top.sv]
// Sorted priority queue: a row of slot cells, one push or pop per cycle.
// Result strobe out_valid is registered and rises in the cycle after start is taken.
// Throughput: one word per cycle; busy stays low, all cells shift in parallel.
// Reset (synchronous, rst_n low) empties the queue and drops the strobe;
// slot contents are not cleared. The receiver cannot stall the results.
module sorted_priority_queue_top import spq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_action,
  input  logic signed [31:0] in_data_in,
  input  logic [15:0]       in_priority_in,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic signed [31:0] out_data_out,
  output logic [15:0]       out_priority_out,
  output logic [4:0]        out_occupancy
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             valid_r, valid_nxt;
  logic [1:0]       status_r, status_nxt;
  data_t            dout_r, dout_nxt;
  prio_t            pout_r, pout_nxt;

  logic       take, full, empty;
  cell_cmd_t  cmd;
  cell_link_t links [DEPTH];
  cell_link_t edge_left, edge_right;

  // every cell updates in the same cycle, so nothing ever waits
  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  assign cmd.en   = take && ((in_action == ACT_PUSH) ? !full : !empty);
  assign cmd.pop  = (in_action == ACT_POP);
  assign cmd.data = data_t'(in_data_in);
  assign cmd.prio = in_priority_in[PRIO_BITS-1:0];

  // head sees a keeping neighbor so it loads the new word; tail shifts in filler
  assign edge_left  = '{keep: 1'b1, data: '0, prio: '0};
  assign edge_right = '{keep: 1'b0, data: '0, prio: '0};

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic occ;
    assign occ = (CNT_W'(i) < cnt_r);
    spq_cell u_cell (
      .clk      (clk),
      .occupied (occ),
      .cmd      (cmd),
      .left_in  ((i == 0) ? edge_left : links[(i == 0) ? 0 : i - 1]),
      .right_in ((i == DEPTH - 1) ? edge_right : links[(i == DEPTH - 1) ? i : i + 1]),
      .link_out (links[i])
    );
  end

  // occupancy and result word
  always_comb begin
    cnt_nxt    = cnt_r;
    valid_nxt  = take;
    status_nxt = ST_DONE;
    dout_nxt   = '0;
    pout_nxt   = '0;
    if (take) begin
      if (in_action == ACT_PUSH) begin
        if (full) status_nxt = ST_FULL;
        else      cnt_nxt    = cnt_r + CNT_W'(1);
      end else begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cnt_nxt  = cnt_r - CNT_W'(1);
          dout_nxt = links[0].data;
          pout_nxt = links[0].prio;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
    status_r <= status_nxt;
    dout_r   <= dout_nxt;
    pout_r   <= pout_nxt;
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_data_out     = dout_r;
  assign out_priority_out = PRIO_W'(pout_r);
  assign out_occupancy    = OCC_W'(cnt_r);

endmodule

[sv/spq_cell.sv]
// one slot of the sorted queue: holds a word and its priority
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  logic       occupied,
  input  cell_cmd_t  cmd,
  input  cell_link_t left_in,
  input  cell_link_t right_in,
  output cell_link_t link_out
);

  data_t data_r, data_nxt;
  prio_t prio_r, prio_nxt;
  logic  keep;

  // entry stays put on a push when it sorts at or ahead of the new word
  assign keep = occupied && (prio_r <= cmd.prio);

  assign link_out.keep = keep;
  assign link_out.data = data_r;
  assign link_out.prio = prio_r;

  // push shifts toward the tail, pop shifts toward the head
  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (cmd.en) begin
      if (cmd.pop) begin
        data_nxt = right_in.data;
        prio_nxt = right_in.prio;
      end else if (!keep) begin
        if (left_in.keep) begin
          data_nxt = cmd.data;
          prio_nxt = cmd.prio;
        end else begin
          data_nxt = left_in.data;
          prio_nxt = left_in.prio;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

endmodule

[sv/spq_checker.sv]
// port-level checks on the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_top_macros.svh
`include "sorted_priority_queue_top_macros.svh"

module spq_checker import spq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_data_out,
  input logic [15:0] out_priority_out,
  input logic [4:0]  out_occupancy
);

  // every taken word yields exactly one strobe, in the next cycle
  `SPQ_ASSERT_NEXT(a_result_follows, start && !busy, out_valid, "missing result strobe")
  `SPQ_ASSERT_NEXT(a_no_spurious, !(start && !busy), !out_valid, "result without a word")

  // a dropped push reports a full queue
  `SPQ_ASSERT_NOW(a_full_occ, out_valid && (out_status == ST_FULL),
    out_occupancy == OCC_W'(DEPTH), "full status with wrong occupancy")

  // an empty pop reports nothing held and zero payload
  `SPQ_ASSERT_NOW(a_empty_pop, out_valid && (out_status == ST_EMPTY),
    (out_occupancy == '0) && (out_data_out == '0) && (out_priority_out == '0),
    "empty status with nonzero fields")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);
